// ----- src/ecw_pkg.sv -----
// Shared types and constants for the Euler circuit walker.
// Holds field widths, action and status codes, walk phase, controller states
// and the command struct toward the graph memory. No dependencies.
package ecw_pkg;

  localparam int VERT_W = 7;
  localparam int MULT_W = 8;
  localparam int DEG_W  = 9;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [MULT_W-1:0] MULT_MAX = 8'd255;
  localparam logic [DEG_W-1:0]  DEG_MAX  = 9'd511;

  // input word actions
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_NEXT  = 2'd2;

  // result word status codes
  localparam logic [STAT_W-1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMITTED  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FINISHED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_REJECTED = 2'd3;

  typedef enum logic [1:0] {
    PH_LOADING,
    PH_WALKING,
    PH_FINISHED
  } phase_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CHK,
    ST_ADD_WR2,
    ST_SCAN,
    ST_TAKE1,
    ST_TAKE2,
    ST_POP,
    ST_TOP_RD,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic mat_re;
    logic mat_we;
    logic deg_re;
    logic deg_we;
    logic clr_req;
  } mem_cmd_t;

endpackage

// ----- src/ecw_graph_mem.sv -----
// Graph storage: edge count matrix and per-vertex degree memories with the
// sweep that zeroes them after reset and on a clear request.
// Depends on ecw_pkg.
module ecw_graph_mem import ecw_pkg::*; #(
  parameter int VERT_IDX_W = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mem_cmd_t                cmd,
  input  logic [2*VERT_IDX_W-1:0] mat_raddr,
  input  logic [2*VERT_IDX_W-1:0] mat_waddr,
  input  logic [MULT_W-1:0]       mat_wdata,
  input  logic [VERT_IDX_W-1:0]   deg_raddr_a,
  input  logic [VERT_IDX_W-1:0]   deg_raddr_b,
  input  logic [VERT_IDX_W-1:0]   deg_waddr,
  input  logic [DEG_W-1:0]        deg_wdata,
  output logic [MULT_W-1:0]       mat_rdata,
  output logic [DEG_W-1:0]        deg_rdata_a,
  output logic [DEG_W-1:0]        deg_rdata_b,
  output logic                    clr_busy
);

  localparam int MAT_AW    = 2 * VERT_IDX_W;
  localparam int MAT_DEPTH = 1 << MAT_AW;
  localparam int DEG_DEPTH = 1 << VERT_IDX_W;

  logic [MULT_W-1:0] mat_mem [MAT_DEPTH];
  logic [DEG_W-1:0]  deg_mem [DEG_DEPTH];

  logic              busy_r, busy_nxt;
  logic [MAT_AW-1:0] sweep_r, sweep_nxt;
  logic              deg_sweep;

  logic [MULT_W-1:0] mat_rdata_r;
  logic [DEG_W-1:0]  deg_rdata_a_r;
  logic [DEG_W-1:0]  deg_rdata_b_r;

  always_comb begin
    busy_nxt  = busy_r;
    sweep_nxt = sweep_r;
    if (cmd.clr_req) begin
      busy_nxt  = 1'b1;
      sweep_nxt = '0;
    end else if (busy_r) begin
      sweep_nxt = sweep_r + MAT_AW'(1);
      if (sweep_r == {MAT_AW{1'b1}}) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // degree entries live in the low part of the sweep range
  assign deg_sweep = (sweep_r[MAT_AW-1:VERT_IDX_W] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      sweep_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      sweep_r <= sweep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mat_mem[sweep_r] <= '0;
    end else if (cmd.mat_we) begin
      mat_mem[mat_waddr] <= mat_wdata;
    end
    if (cmd.mat_re) begin
      mat_rdata_r <= mat_mem[mat_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (deg_sweep) begin
        deg_mem[sweep_r[VERT_IDX_W-1:0]] <= '0;
      end
    end else if (cmd.deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    if (cmd.deg_re) begin
      deg_rdata_a_r <= deg_mem[deg_raddr_a];
      deg_rdata_b_r <= deg_mem[deg_raddr_b];
    end
  end

  assign mat_rdata   = mat_rdata_r;
  assign deg_rdata_a = deg_rdata_a_r;
  assign deg_rdata_b = deg_rdata_b_r;
  assign clr_busy    = busy_r;

endmodule

// ----- src/euler_circuit_walker_core.sv -----
// Euler circuit walker: loads an undirected multigraph edge by edge and walks
// it with a stack, one circuit vertex per request. Depends on ecw_pkg and
// instantiates ecw_graph_mem.
//
// Usage:
//   Input words (in_valid/in_stall) carry an action and two 1-based endpoints:
//   clear the graph, add an edge, or ask for the next circuit vertex. Every
//   accepted input word yields exactly one result word (out_valid/out_stall)
//   with a status, the emitted vertex and a last flag.
//   cfg_wr_en/cfg_wr_data set the start vertex; write it only while idle.
//   One word at a time: an add reads the matrix cell and both degrees, checks
//   them and writes the cell and degree for each endpoint (once for a self-loop);
//   a next scans the top vertex's row through the single matrix read port,
//   takes the first edge found, pushes the neighbour and scans again, and pops
//   the top once its row is empty. A new word can be taken in the cycle after the result load.
//   Clear and reset run a sweep over the matrix memory of 2^(2*ceil(log2 V))
//   entries, V the vertex count (4096 at the default of 64); no input word
//   is taken during it. After reset the start vertex is 1 and the graph is empty.
//   A stalled result word holds in the output register; the block finishes
//   the current word, waits there and takes no input until it is loaded.
module euler_circuit_walker_core import ecw_pkg::*; #(
  parameter int NUM_VERTICES = 64,
  parameter int MAX_EDGES    = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [VERT_W-1:0] in_vertex_a,
  input  logic [VERT_W-1:0] in_vertex_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [VERT_W-1:0] out_circuit_vertex,
  output logic              out_last_vertex,
  input  logic              cfg_wr_en,
  input  logic [VERT_W-1:0] cfg_wr_data
);

  localparam int VW     = $clog2(NUM_VERTICES);
  localparam int MAT_AW = 2 * VW;
  localparam int CW     = VW + 1;
  localparam int IW     = (VW + 1 > VERT_W) ? VW + 1 : VERT_W;
  localparam int SLOTS  = MAX_EDGES + 1;
  localparam int SW     = $clog2(SLOTS);
  localparam int DW     = $clog2(SLOTS + 1);
  localparam int EW     = $clog2(MAX_EDGES + 1);

  function automatic logic vertex_ok(input logic [VERT_W-1:0] v);
    return (v != '0) && (IW'(v) <= IW'(NUM_VERTICES));
  endfunction

  function automatic logic [VW-1:0] to_idx(input logic [VERT_W-1:0] v);
    logic [IW-1:0] t;
    t = IW'(v) - IW'(1);
    return t[VW-1:0];
  endfunction

  function automatic logic [VERT_W-1:0] to_vert(input logic [VW-1:0] idx);
    logic [IW-1:0] t;
    t = IW'(idx) + IW'(1);
    return t[VERT_W-1:0];
  endfunction

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [VERT_W-1:0] start_r;
  logic [VERT_W-1:0] a_r, a_nxt;
  logic [VERT_W-1:0] b_r, b_nxt;
  logic [VERT_W-1:0] top_r, top_nxt;
  logic [VERT_W-1:0] nb_r, nb_nxt;
  logic [MULT_W-1:0] m_r, m_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [VW-1:0]     chk_col_r, chk_col_nxt;
  logic              pend_r, pend_nxt;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic [EW-1:0]     edges_r, edges_nxt;
  logic              clr_resp_r, clr_resp_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [VERT_W-1:0] res_vertex_r, res_vertex_nxt;
  logic              res_last_r, res_last_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [VERT_W-1:0] out_vertex_r;
  logic              out_last_r;
  logic              out_load;

  logic              in_acc;
  logic              out_free;

  mem_cmd_t          cmd;
  logic [MAT_AW-1:0] mat_raddr, mat_waddr;
  logic [MULT_W-1:0] mat_wdata, mat_rdata;
  logic [VW-1:0]     deg_waddr;
  logic [DEG_W-1:0]  deg_wdata, deg_rdata_a, deg_rdata_b;
  logic              clr_busy;

  logic [VERT_W-1:0] stk_mem [SLOTS];
  logic              stk_we, stk_re;
  logic [SW-1:0]     stk_waddr, stk_raddr;
  logic [VERT_W-1:0] stk_wdata;
  logic [VERT_W-1:0] stk_rdata_r;

  logic [VW-1:0]     a_idx, b_idx, top_idx;
  logic              self_loop;
  logic              add_bad;
  logic              scan_issue, scan_found, scan_none;
  logic [DW-1:0]     below_top;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign a_idx     = to_idx(a_r);
  assign b_idx     = to_idx(b_r);
  assign top_idx   = to_idx(top_r);
  assign self_loop = (a_r == b_r);
  assign below_top = depth_r - DW'(2);

  assign add_bad = (mat_rdata == MULT_MAX) ||
                   (self_loop ? (deg_rdata_a >= DEG_MAX - DEG_W'(1))
                              : ((deg_rdata_a == DEG_MAX) || (deg_rdata_b == DEG_MAX)));

  assign scan_issue = (col_r < CW'(NUM_VERTICES));
  assign scan_found = pend_r && (mat_rdata != '0);
  assign scan_none  = pend_r && (mat_rdata == '0) && (chk_col_r == VW'(NUM_VERTICES - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (!clr_busy) begin
          state_nxt = clr_resp_r ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_action)
            ACT_CLEAR: state_nxt = ST_CLR;
            ACT_ADD: begin
              if (phase_r == PH_LOADING && vertex_ok(in_vertex_a) &&
                  vertex_ok(in_vertex_b) && edges_r < EW'(MAX_EDGES)) begin
                state_nxt = ST_ADD_RD;
              end else begin
                state_nxt = ST_RESP;
              end
            end
            ACT_NEXT: begin
              if (phase_r == PH_WALKING ||
                  (phase_r == PH_LOADING && vertex_ok(start_r))) begin
                state_nxt = ST_SCAN;
              end else begin
                state_nxt = ST_RESP;
              end
            end
            default: state_nxt = ST_RESP;
          endcase
        end
      end
      ST_ADD_RD:  state_nxt = ST_ADD_CHK;
      ST_ADD_CHK: state_nxt = (add_bad || self_loop) ? ST_RESP : ST_ADD_WR2;
      ST_ADD_WR2: state_nxt = ST_RESP;
      ST_SCAN: begin
        if (scan_found) begin
          state_nxt = ST_TAKE1;
        end else if (scan_none) begin
          state_nxt = ST_POP;
        end
      end
      ST_TAKE1:  state_nxt = ST_TAKE2;
      ST_TAKE2:  state_nxt = ST_SCAN;
      ST_POP:    state_nxt = (depth_r == DW'(1)) ? ST_RESP : ST_TOP_RD;
      ST_TOP_RD: state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    phase_nxt      = phase_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    top_nxt        = top_r;
    nb_nxt         = nb_r;
    m_nxt          = m_r;
    col_nxt        = col_r;
    chk_col_nxt    = chk_col_r;
    pend_nxt       = pend_r;
    depth_nxt      = depth_r;
    edges_nxt      = edges_r;
    clr_resp_nxt   = clr_resp_r;
    res_status_nxt = res_status_r;
    res_vertex_nxt = res_vertex_r;
    res_last_nxt   = res_last_r;
    out_load       = 1'b0;

    cmd       = '0;
    mat_raddr = {a_idx, b_idx};
    mat_waddr = {a_idx, b_idx};
    mat_wdata = mat_rdata + MULT_W'(1);
    deg_waddr = a_idx;
    deg_wdata = deg_rdata_a + DEG_W'(1);
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_waddr = depth_r[SW-1:0];
    stk_raddr = below_top[SW-1:0];
    stk_wdata = nb_r;

    unique case (state_r)
      ST_CLR: ;
      ST_IDLE: begin
        if (in_acc) begin
          res_vertex_nxt = '0;
          res_last_nxt   = 1'b0;
          res_status_nxt = STAT_REJECTED;
          col_nxt        = '0;
          pend_nxt       = 1'b0;
          case (in_action)
            ACT_CLEAR: begin
              cmd.clr_req    = 1'b1;
              clr_resp_nxt   = 1'b1;
              res_status_nxt = STAT_ACCEPTED;
              phase_nxt      = PH_LOADING;
              depth_nxt      = '0;
              edges_nxt      = '0;
            end
            ACT_ADD: begin
              a_nxt = in_vertex_a;
              b_nxt = in_vertex_b;
            end
            ACT_NEXT: begin
              if (phase_r == PH_FINISHED) begin
                res_status_nxt = STAT_FINISHED;
              end else if (phase_r == PH_LOADING && vertex_ok(start_r)) begin
                // seed the stack with the start vertex
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = start_r;
                top_nxt   = start_r;
                depth_nxt = DW'(1);
                phase_nxt = PH_WALKING;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ADD_RD: begin
        cmd.mat_re = 1'b1;
        cmd.deg_re = 1'b1;
      end
      ST_ADD_CHK: begin
        if (add_bad) begin
          res_status_nxt = STAT_REJECTED;
        end else begin
          cmd.mat_we     = 1'b1;
          cmd.deg_we     = 1'b1;
          deg_wdata      = deg_rdata_a + (self_loop ? DEG_W'(2) : DEG_W'(1));
          res_status_nxt = STAT_ACCEPTED;
          if (self_loop) begin
            edges_nxt = edges_r + EW'(1);
          end
        end
      end
      ST_ADD_WR2: begin
        cmd.mat_we = 1'b1;
        cmd.deg_we = 1'b1;
        mat_waddr  = {b_idx, a_idx};
        deg_waddr  = b_idx;
        deg_wdata  = deg_rdata_b + DEG_W'(1);
        edges_nxt  = edges_r + EW'(1);
      end
      ST_SCAN: begin
        // one row entry read per cycle, checked the cycle after
        mat_raddr = {top_idx, col_r[VW-1:0]};
        if (scan_issue) begin
          cmd.mat_re  = 1'b1;
          col_nxt     = col_r + CW'(1);
          chk_col_nxt = col_r[VW-1:0];
          pend_nxt    = 1'b1;
        end
        if (scan_found) begin
          m_nxt  = mat_rdata;
          nb_nxt = to_vert(chk_col_r);
        end
      end
      ST_TAKE1: begin
        cmd.mat_we = 1'b1;
        mat_waddr  = {top_idx, to_idx(nb_r)};
        mat_wdata  = m_r - MULT_W'(1);
      end
      ST_TAKE2: begin
        // mirror cell, then push the neighbour
        cmd.mat_we = 1'b1;
        mat_waddr  = {to_idx(nb_r), top_idx};
        mat_wdata  = m_r - MULT_W'(1);
        stk_we     = 1'b1;
        depth_nxt  = depth_r + DW'(1);
        top_nxt    = nb_r;
        col_nxt    = '0;
        pend_nxt   = 1'b0;
      end
      ST_POP: begin
        res_status_nxt = STAT_EMITTED;
        res_vertex_nxt = top_r;
        depth_nxt      = depth_r - DW'(1);
        if (depth_r == DW'(1)) begin
          res_last_nxt = 1'b1;
          phase_nxt    = PH_FINISHED;
        end else begin
          res_last_nxt = 1'b0;
          stk_re       = 1'b1;
        end
      end
      ST_TOP_RD: begin
        top_nxt = stk_rdata_r;
      end
      ST_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          clr_resp_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  ecw_graph_mem #(
    .VERT_IDX_W (VW)
  ) u_graph_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .mat_raddr   (mat_raddr),
    .mat_waddr   (mat_waddr),
    .mat_wdata   (mat_wdata),
    .deg_raddr_a (a_idx),
    .deg_raddr_b (b_idx),
    .deg_waddr   (deg_waddr),
    .deg_wdata   (deg_wdata),
    .mat_rdata   (mat_rdata),
    .deg_rdata_a (deg_rdata_a),
    .deg_rdata_b (deg_rdata_b),
    .clr_busy    (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_r <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      phase_r     <= PH_LOADING;
      start_r     <= VERT_W'(1);
      depth_r     <= '0;
      edges_r     <= '0;
      clr_resp_r  <= 1'b0;
      pend_r      <= 1'b0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      depth_r     <= depth_nxt;
      edges_r     <= edges_nxt;
      clr_resp_r  <= clr_resp_nxt;
      pend_r      <= pend_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        start_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    top_r        <= top_nxt;
    nb_r         <= nb_nxt;
    m_r          <= m_nxt;
    chk_col_r    <= chk_col_nxt;
    res_status_r <= res_status_nxt;
    res_vertex_r <= res_vertex_nxt;
    res_last_r   <= res_last_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_vertex_r <= res_vertex_r;
      out_last_r   <= res_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_circuit_vertex = out_vertex_r;
  assign out_last_vertex    = out_last_r;

endmodule

// ----- tb/euler_circuit_walker_core_tb.sv -----
// Self-checking bench for euler_circuit_walker_core: loads random multigraphs, walks
// them and checks every result word against an in-bench Hierholzer predictor.
// Depends on ecw_pkg and the core RTL.
module euler_circuit_walker_core_tb;
  import ecw_pkg::*;

  localparam int NV          = 64;
  localparam int ME          = 255;
  localparam int STACK_SLOTS = ME + 1;
  localparam int ITEMS       = 2000;
  localparam int QUIET_LIMIT = 50000;
  localparam int SETTLE      = 80;
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VERT_W-1:0] vertex;
    logic              is_last;
  } walk_result_t;

  class circuit_scoreboard;
    bit [MULT_W-1:0] multiplicity [NV][NV];
    bit [DEG_W-1:0]  degree [NV];
    bit [VERT_W-1:0] walk_stack [STACK_SLOTS];
    int              depth;
    int              edges;
    phase_t          phase;
    bit [VERT_W-1:0] start_vertex;
    walk_result_t    expected [$];
    int              errors;

    function new();
      wipe_graph();
      start_vertex = VERT_W'(1);
      errors = 0;
    endfunction

    function void wipe_graph();
      foreach (multiplicity[i, j]) multiplicity[i][j] = '0;
      foreach (degree[i]) degree[i] = '0;
      depth = 0;
      edges = 0;
      phase = PH_LOADING;
    endfunction

    function bit vertex_ok(int v);
      return v >= 1 && v <= NV;
    endfunction

    function logic [STAT_W-1:0] try_add_edge(int a, int b);
      if (phase != PH_LOADING || !vertex_ok(a) || !vertex_ok(b)) return STAT_REJECTED;
      if (edges >= ME) return STAT_REJECTED;
      if (multiplicity[a-1][b-1] >= MULT_MAX) return STAT_REJECTED;
      if (a == b) begin
        if (int'(degree[a-1]) + 2 > int'(DEG_MAX)) return STAT_REJECTED;
        multiplicity[a-1][a-1]++;
        degree[a-1] += DEG_W'(2);
      end else begin
        if (int'(degree[a-1]) + 1 > int'(DEG_MAX) ||
            int'(degree[b-1]) + 1 > int'(DEG_MAX)) return STAT_REJECTED;
        multiplicity[a-1][b-1]++;
        multiplicity[b-1][a-1]++;
        degree[a-1]++;
        degree[b-1]++;
      end
      edges++;
      return STAT_ACCEPTED;
    endfunction

    function int first_neighbour(int v);
      for (int j = 1; j <= NV; j++)
        if (multiplicity[v-1][j-1] != 0) return j;
      return 0;
    endfunction

    function void remove_edge(int u, int w);
      if (u == w) begin
        multiplicity[u-1][u-1]--;
        degree[u-1] -= DEG_W'(2);
      end else begin
        multiplicity[u-1][w-1]--;
        multiplicity[w-1][u-1]--;
        degree[u-1]--;
        degree[w-1]--;
      end
    endfunction

    function walk_result_t advance_walk();
      walk_result_t r;
      int top;
      int nb;
      r = '0;
      if (phase == PH_FINISHED) begin
        r.status = STAT_FINISHED;
        return r;
      end
      if (phase == PH_LOADING) begin
        if (!vertex_ok(start_vertex)) begin
          r.status = STAT_REJECTED;
          return r;
        end
        walk_stack[0] = start_vertex;
        depth = 1;
        phase = PH_WALKING;
      end
      top = walk_stack[depth-1];
      nb = first_neighbour(top);
      // push along the lowest neighbour until the top runs out of edges
      while (degree[top-1] != 0 && nb != 0) begin
        remove_edge(top, nb);
        if (depth < STACK_SLOTS) begin
          walk_stack[depth] = VERT_W'(nb);
          depth++;
        end
        top = walk_stack[depth-1];
        nb = first_neighbour(top);
      end
      depth--;
      r.status = STAT_EMITTED;
      r.vertex = VERT_W'(top);
      if (depth == 0) begin
        r.is_last = 1'b1;
        phase = PH_FINISHED;
      end
      return r;
    endfunction

    function void note_word(logic [ACT_W-1:0] action, logic [VERT_W-1:0] a,
                            logic [VERT_W-1:0] b);
      walk_result_t r;
      r = '0;
      case (action)
        ACT_CLEAR: wipe_graph();
        ACT_ADD:   r.status = try_add_edge(a, b);
        ACT_NEXT:  r = advance_walk();
        default:   r.status = STAT_REJECTED;
      endcase
      expected.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_word(logic [STAT_W-1:0] status, logic [VERT_W-1:0] vertex, logic is_last);
      walk_result_t want;
      if (expected.size() == 0) begin
        report($sformatf("unexpected result word status %0d vertex %0d", status, vertex));
        return;
      end
      want = expected.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, want %0d", status, want.status));
      if (vertex !== want.vertex)
        report($sformatf("circuit_vertex %0d, want %0d", vertex, want.vertex));
      if (is_last !== want.is_last)
        report($sformatf("last_vertex %0b, want %0b", is_last, want.is_last));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ACT_W-1:0]  in_action = ACT_CLEAR;
  logic [VERT_W-1:0] in_vertex_a = '0;
  logic [VERT_W-1:0] in_vertex_b = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [VERT_W-1:0] out_circuit_vertex;
  logic              out_last_vertex;
  logic              cfg_wr_en = 1'b0;
  logic [VERT_W-1:0] cfg_wr_data = '0;

  circuit_scoreboard sb = new();
  bit calm = 1'b0;
  int words_sent = 0;
  int quiet_cycles = 0;

  euler_circuit_walker_core #(
    .NUM_VERTICES(NV),
    .MAX_EDGES(ME)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_vertex_a(in_vertex_a),
    .in_vertex_b(in_vertex_b),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_circuit_vertex(out_circuit_vertex),
    .out_last_vertex(out_last_vertex),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 22);

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) sb.note_word(in_action, in_vertex_a, in_vertex_b);
      if (out_valid && !out_stall)
        sb.check_word(out_status, out_circuit_vertex, out_last_vertex);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic [ACT_W-1:0] action, int a, int b);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = action;
    in_vertex_a = VERT_W'(a);
    in_vertex_b = VERT_W'(b);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.expected.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_start(int v);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = VERT_W'(v);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.start_vertex = VERT_W'(v);
  endtask

  task automatic noise_word();
    case ($urandom_range(2))
      0:       send_word(ACT_SPARE, $urandom_range(127), $urandom_range(127));
      1:       send_word(ACT_ADD, 0, $urandom_range(127));
      default: send_word(ACT_ADD, $urandom_range(NV, 1), $urandom_range(127, NV + 1));
    endcase
  endtask

  // Closed walk from the start vertex: every edge reachable, all degrees even.
  task automatic load_circuit(int len, int lo, int hi);
    int here;
    int there;
    here = sb.start_vertex;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) noise_word();
      there = (i == len - 1) ? int'(sb.start_vertex) : int'($urandom_range(hi, lo));
      if ($urandom_range(1)) send_word(ACT_ADD, here, there);
      else send_word(ACT_ADD, there, here);
      here = there;
    end
  endtask

  task automatic load_scatter(int len, int lo, int hi, bit avoid_start);
    int a;
    int b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) noise_word();
      a = $urandom_range(hi, lo);
      b = $urandom_range(hi, lo);
      if (avoid_start && a == sb.start_vertex) a = sb.start_vertex % NV + 1;
      if (avoid_start && b == sb.start_vertex) b = sb.start_vertex % NV + 1;
      send_word(ACT_ADD, a, b);
    end
  endtask

  task automatic walk_graph();
    int stop_at;
    int n;
    stop_at = ($urandom_range(99) < 12) ? $urandom_range(10, 1) : 600;
    n = 0;
    while (sb.phase != PH_FINISHED && n < stop_at) begin
      // adds during the walk must bounce
      if (sb.phase == PH_WALKING && $urandom_range(99) < 5)
        send_word(ACT_ADD, $urandom_range(NV, 1), $urandom_range(NV, 1));
      send_word(ACT_NEXT, $urandom_range(127), $urandom_range(127));
      n++;
    end
    if (sb.phase == PH_FINISHED)
      repeat ($urandom_range(2)) send_word(ACT_NEXT, $urandom_range(127), $urandom_range(127));
  endtask

  initial begin
    int phase_no;
    int pick;
    int len;
    int lo;
    int hi;
    int s;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty graph: start emitted alone, then the walk is over
    send_word(ACT_NEXT, 0, 0);
    send_word(ACT_NEXT, 127, 127);
    send_word(ACT_ADD, 1, 2);
    send_word(ACT_SPARE, 127, 127);
    send_word(ACT_CLEAR, 0, 0);
    send_word(ACT_ADD, 0, 5);
    send_word(ACT_ADD, 5, 65);
    send_word(ACT_ADD, 127, 0);
    send_word(ACT_ADD, 1, 64);
    send_word(ACT_ADD, 64, 64);
    send_word(ACT_ADD, 64, 1);
    send_word(ACT_ADD, 1, 1);
    send_word(ACT_NEXT, 0, 0);
    send_word(ACT_ADD, 2, 3);
    repeat (5) send_word(ACT_NEXT, 0, 0);
    send_word(ACT_CLEAR, 0, 0);
    write_start(0);
    send_word(ACT_NEXT, 0, 0);
    send_word(ACT_ADD, 2, 3);
    write_start(127);
    send_word(ACT_NEXT, 0, 0);
    write_start(64);
    send_word(ACT_NEXT, 0, 0);
    send_word(ACT_NEXT, 0, 0);

    phase_no = 0;
    while (words_sent < ITEMS) begin
      phase_no++;
      calm = (phase_no >= 5 && phase_no < 10);
      pick = $urandom_range(99);
      if (pick < 4) begin
        // bad start: next bounces and the graph stays in loading
        s = $urandom_range(1) ? 0 : int'($urandom_range(127, NV + 1));
        write_start(s);
        send_word(ACT_CLEAR, 0, 0);
        send_word(ACT_ADD, $urandom_range(NV, 1), $urandom_range(NV, 1));
        repeat ($urandom_range(2, 1)) send_word(ACT_NEXT, 0, 0);
        write_start($urandom_range(NV, 1));
      end else if (pick < 14) begin
        case ($urandom_range(3))
          0:       s = 1;
          1:       s = NV;
          default: s = $urandom_range(NV, 1);
        endcase
        write_start(s);
      end
      send_word(ACT_CLEAR, $urandom_range(127), $urandom_range(127));
      if (phase_no == 3) begin
        // fill to the edge limit with self-loops; the last add bounces
        repeat (ME + 1) send_word(ACT_ADD, sb.start_vertex, sb.start_vertex);
      end else begin
        len = ($urandom_range(99) < 10) ? $urandom_range(80, 25) : $urandom_range(24, 1);
        if ($urandom_range(99) < 20) begin
          lo = 1;
          hi = NV;
        end else begin
          lo = $urandom_range(NV, 1);
          hi = lo + $urandom_range(12);
          if (hi > NV) hi = NV;
        end
        pick = $urandom_range(99);
        if (pick < 65) load_circuit(len, lo, hi);
        else if (pick < 90) load_scatter(len, lo, hi, 1'b0);
        else load_scatter($urandom_range(4), 1, NV, 1'b1);
      end
      walk_graph();
    end

    in_valid = 1'b0;
    calm = 1'b0;
    while (sb.expected.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
